// File: sv/cgad_pkg.sv
// Shared types and constants for the CTC greedy argmax decoder.
// No dependencies; imported by the result queue and the top level.
package cgad_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CLASS_COUNT     = 2'd0;
    localparam logic [1:0] CFG_DICTIONARY_SIZE = 2'd1;
    localparam logic [1:0] CFG_IGNORED_CLASSES = 2'd2;
    localparam logic [1:0] CFG_ZERO_POINT      = 2'd3;

    // register reset values
    localparam logic [15:0] RST_CLASS_COUNT     = 16'd18385;
    localparam logic [15:0] RST_DICTIONARY_SIZE = 16'd18382;
    localparam logic [7:0]  RST_IGNORED_CLASSES = 8'd2;
    localparam logic [7:0]  RST_ZERO_POINT      = 8'd0;

    // result kinds
    localparam logic RESULT_CHAR    = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    // saturation bound of the running score sum
    localparam int SUM_LIMIT = 260865;

    typedef struct packed {
        logic               result_kind;
        logic [15:0]        char_index;
        logic [7:0]         char_score;
        logic [9:0]         char_count;
        logic signed [18:0] score_sum;
        logic               last_result;
    } t_result;

endpackage

// File: sv/cgad_result_fifo.sv
// Small result queue for the CTC greedy decoder: up to two pushes and one pop per cycle.
// Depends on cgad_pkg (t_result).
module cgad_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push0,
    input  logic             i_push1,
    input  cgad_pkg::t_result i_data0,
    input  cgad_pkg::t_result i_data1,
    output logic             o_room,
    output logic             o_valid,
    output cgad_pkg::t_result o_data,
    input  logic             i_ready
);
    import cgad_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr1;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = ptr_inc(r_wr_ptr);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push0 && i_push1) begin
            n_wr_ptr = ptr_inc(wr_ptr1);
        end else if (i_push0) begin
            n_wr_ptr = wr_ptr1;
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push0) + CNT_W'(i_push1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

    // second slot is only used together with the first
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1 |-> i_push0)
        else $error("second push without first");

    // producer only pushes when two slots are free
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push0 |-> o_room)
        else $error("push without room");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue overflow");

endmodule

// File: sv/ctc_greedy_argmax_decoder_core.sv
// Top level of the CTC greedy argmax decoder: input register, decode logic, result queue.
// Depends on cgad_pkg and cgad_result_fifo.
//
// Scores stream in one byte per transaction, class by class, timestep by
// timestep. The block accepts one input transaction per clock cycle: a
// registered input stage feeds a single pass of compare/update logic that
// keeps the running argmax (lowest class wins a tie) and, at the end of a
// timestep, applies the CTC greedy rules (a blank becomes the repeat history,
// repeats are dropped, classes past the dictionary are skipped). Results go
// into a four-entry queue; a result passes through the input register and
// then the result queue on its way to the output. An input that both closes a
// character timestep and ends the sequence yields two results (character,
// then summary with last_result set), so the sustained rate is one input per
// cycle as long as the output side drains about one result per cycle; the
// queue absorbs the extra summary and the input stalls only when fewer than
// two queue slots are free. Configuration writes take effect immediately and
// are meant to be issued while the block is idle. char_count shows the low
// ten bits of a counter that saturates at 2^COUNT_WIDTH-1; score_sum
// saturates at +/-260865.
module ctc_greedy_argmax_decoder_core #(
    parameter int CLASS_INDEX_WIDTH = 16,
    parameter int COUNT_WIDTH       = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_score,
    input  logic               i_end_of_sequence,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_result_kind,
    output logic [15:0]        o_char_index,
    output logic [7:0]         o_char_score,
    output logic [9:0]         o_char_count,
    output logic signed [18:0] o_score_sum,
    output logic               o_last_result
);
    import cgad_pkg::*;

    localparam int CIW     = CLASS_INDEX_WIDTH;
    // width for class-vs-register compares and the dictionary index
    localparam int CMP_W   = ((CIW > 16) ? CIW : 16) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic signed [20:0] LIM_POS = 21'(SUM_LIMIT);
    localparam logic signed [20:0] LIM_NEG = -21'(SUM_LIMIT);
    localparam int QUEUE_DEPTH = 4;

    // configuration registers
    logic [15:0] r_class_count;
    logic [15:0] r_dictionary_size;
    logic [7:0]  r_ignored_classes;
    logic [7:0]  r_zero_point;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_score;
    logic        r_eos;

    // decoder state
    logic [15:0]             r_class_position, n_class_position;
    logic [7:0]              r_best_score, n_best_score;
    logic [CIW-1:0]          r_best_class, n_best_class;
    logic [CIW-1:0]          r_prev_class, n_prev_class;
    logic                    r_prev_valid, n_prev_valid;
    logic [COUNT_WIDTH-1:0]  r_decoded_count, n_decoded_count;
    logic signed [19:0]      r_score_total, n_score_total;

    // decode logic
    logic                    fire;
    logic                    room;
    logic [15:0]             per_step;
    logic                    step_end;
    logic                    take;
    logic [7:0]              cur_score;
    logic [CIW-1:0]          cur_class;
    logic [CMP_W-1:0]        win_ext;
    logic [CMP_W-1:0]        ign_ext;
    logic [CMP_W-1:0]        dict_offset;
    logic                    is_blank;
    logic                    is_repeat;
    logic                    in_dict;
    logic                    have_char;
    logic signed [20:0]      sum_raw;
    logic signed [19:0]      sum_sat;
    t_result                 char_res;
    t_result                 summary_res;
    t_result                 push_data0;
    t_result                 push_data1;
    logic                    push0;
    logic                    push1;
    t_result                 out_res;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count     <= RST_CLASS_COUNT;
            r_dictionary_size <= RST_DICTIONARY_SIZE;
            r_ignored_classes <= RST_IGNORED_CLASSES;
            r_zero_point      <= RST_ZERO_POINT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLASS_COUNT:     r_class_count     <= i_cfg_data;
                CFG_DICTIONARY_SIZE: r_dictionary_size <= i_cfg_data;
                CFG_IGNORED_CLASSES: r_ignored_classes <= i_cfg_data[7:0];
                CFG_ZERO_POINT:      r_zero_point      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input stage: refills in the same cycle the held transaction is consumed
    assign fire    = r_in_valid && room;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_score <= i_score;
            r_eos   <= i_end_of_sequence;
        end
    end

    // running argmax and end-of-timestep rules
    always_comb begin
        per_step = (r_class_count == '0) ? 16'd1 : r_class_count;
        step_end = r_eos || (({1'b0, r_class_position} + 17'd1) >= {1'b0, per_step});

        // first class of a timestep always takes; ties keep the lower class
        take      = (r_class_position == '0) || (r_score > r_best_score);
        cur_score = take ? r_score : r_best_score;
        cur_class = take ? CIW'(r_class_position) : r_best_class;

        win_ext     = CMP_W'(cur_class);
        ign_ext     = CMP_W'(r_ignored_classes);
        dict_offset = win_ext - ign_ext;
        is_blank    = win_ext < ign_ext;
        is_repeat   = r_prev_valid && (cur_class == r_prev_class);
        in_dict     = dict_offset < CMP_W'(r_dictionary_size);
        have_char   = step_end && !is_blank && !is_repeat && in_dict;

        // score sum, clamped after every character
        sum_raw = 21'(r_score_total) + 21'(signed'({2'b00, cur_score}))
                  - 21'(signed'({2'b00, r_zero_point}));
        if (sum_raw > LIM_POS) begin
            sum_sat = 20'(LIM_POS);
        end else if (sum_raw < LIM_NEG) begin
            sum_sat = 20'(LIM_NEG);
        end else begin
            sum_sat = sum_raw[19:0];
        end

        n_decoded_count = r_decoded_count;
        n_score_total   = r_score_total;
        if (have_char) begin
            if (r_decoded_count != COUNT_MAX) begin
                n_decoded_count = r_decoded_count + 1'b1;
            end
            n_score_total = sum_sat;
        end

        // result items
        char_res             = '0;
        char_res.result_kind = RESULT_CHAR;
        char_res.char_index  = dict_offset[15:0];
        char_res.char_score  = cur_score;
        char_res.last_result = !r_eos;

        summary_res             = '0;
        summary_res.result_kind = RESULT_SUMMARY;
        summary_res.char_count  = 10'(n_decoded_count);
        summary_res.score_sum   = n_score_total[18:0];
        summary_res.last_result = 1'b1;

        push0      = fire && (have_char || r_eos);
        push1      = fire && have_char && r_eos;
        push_data0 = have_char ? char_res : summary_res;
        push_data1 = summary_res;

        // next state
        n_class_position = r_class_position + 16'd1;
        n_best_score     = cur_score;
        n_best_class     = cur_class;
        n_prev_class     = r_prev_class;
        n_prev_valid     = r_prev_valid;
        if (step_end) begin
            // a repeat leaves previous_class unchanged, so always load the winner
            n_class_position = '0;
            n_best_score     = '0;
            n_best_class     = '0;
            n_prev_class     = cur_class;
            n_prev_valid     = 1'b1;
        end
        if (r_eos) begin
            n_prev_valid    = 1'b0;
            n_decoded_count = '0;
            n_score_total   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_position <= '0;
            r_best_score     <= '0;
            r_best_class     <= '0;
            r_prev_class     <= '0;
            r_prev_valid     <= 1'b0;
            r_decoded_count  <= '0;
            r_score_total    <= '0;
        end else if (fire) begin
            r_class_position <= n_class_position;
            r_best_score     <= n_best_score;
            r_best_class     <= n_best_class;
            r_prev_class     <= n_prev_class;
            r_prev_valid     <= n_prev_valid;
            r_decoded_count  <= n_decoded_count;
            r_score_total    <= n_score_total;
        end
    end

    // result queue
    cgad_result_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_data0 (push_data0),
        .i_data1 (push_data1),
        .o_room  (room),
        .o_valid (o_valid),
        .o_data  (out_res),
        .i_ready (i_ready)
    );

    assign o_result_kind = out_res.result_kind;
    assign o_char_index  = out_res.char_index;
    assign o_char_score  = out_res.char_score;
    assign o_char_count  = out_res.char_count;
    assign o_score_sum   = out_res.score_sum;
    assign o_last_result = out_res.last_result;

    // a summary always closes the results of its input transaction
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == RESULT_SUMMARY) |-> o_last_result)
        else $error("summary without last_result");

    // character results carry no count or sum
    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == RESULT_CHAR) |->
            (o_char_count == '0) && (o_score_sum == '0))
        else $error("character result with summary fields");

    // end of sequence clears the sequence state
    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_eos |=> (r_decoded_count == '0) && (r_score_total == '0)
            && !r_prev_valid && (r_class_position == '0))
        else $error("sequence state not cleared");

    // a closed timestep restarts the class position
    a_step_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && step_end |=> (r_class_position == '0) && (r_best_score == '0))
        else $error("timestep not restarted");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_score_total <= 20'(LIM_POS)) && (r_score_total >= 20'(LIM_NEG)))
        else $error("score total out of range");

endmodule

// File: tb/ctc_greedy_argmax_decoder_core_tb.sv
// Self-checking testbench for ctc_greedy_argmax_decoder_core: directed table, random runs, then a saturation run.
// Depends on cgad_pkg and the decoder RTL; expected results come from an in-bench decode model.
module ctc_greedy_argmax_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cgad_pkg::*;

    localparam int              CYCLE_LIMIT    = 600000;
    localparam int              MAX_REPORTS    = 10;
    localparam int              DRAIN_CYCLES   = 8;
    localparam logic [9:0]      CHAR_COUNT_MAX = 10'h3FF;
    localparam int              PHASE_ITEMS    = 25;
    localparam int              SAT_PAIRS      = 513; // 1026 characters, past the 1023 ceiling

    typedef struct packed {
        logic [15:0] class_count;
        logic [15:0] dict_size;
        logic [7:0]  ignored;
        logic [7:0]  zero_pt;
    } t_decoder_cfg;

    // one row of the directed table: a register set or one score transaction
    typedef struct packed {
        logic         is_cfg;
        t_decoder_cfg cfg;
        logic [7:0]   score;
        logic         eos;
        logic         typed;      // use r0/r1 below instead of the decode model
        logic [1:0]   n;
        t_result      r0;
        t_result      r1;
    } t_stim_row;

    // ---------------------------------------------------------------- DUT I/O
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_CLASS_COUNT;
    logic [15:0]        i_cfg_data = 16'd0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_score = 8'd0;
    logic               i_end_of_sequence = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_result_kind;
    logic [15:0]        o_char_index;
    logic [7:0]         o_char_score;
    logic [9:0]         o_char_count;
    logic signed [18:0] o_score_sum;
    logic               o_last_result;

    ctc_greedy_argmax_decoder_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_score           (i_score),
        .i_end_of_sequence (i_end_of_sequence),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_result_kind     (o_result_kind),
        .o_char_index      (o_char_index),
        .o_char_score      (o_char_score),
        .o_char_count      (o_char_count),
        .o_score_sum       (o_score_sum),
        .o_last_result     (o_last_result)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------- bench state
    int           send_idle  = 0;   // % of cycles the score side sits idle
    int           recv_stall = 0;   // % of cycles the result side holds off
    int           mismatches = 0;
    int           cycle_count = 0;

    t_result      pending_results[$];   // results still owed by the DUT
    t_result      step_results[$];      // results of the latest transaction
    t_stim_row    directed_rows[$];
    logic [7:0]   cur_step[$];
    logic [7:0]   prev_step[$];

    // decode model state, mirrors the block's registers
    t_decoder_cfg model_cfg;
    logic [15:0]  class_pos;
    logic [7:0]   best_score;
    logic [15:0]  best_class;
    logic [15:0]  prev_class;
    logic         prev_known;
    logic [9:0]   char_total;
    int           score_total;

    // ------------------------------------------------------- result builders
    function automatic t_result char_res(input logic [15:0] idx, input logic [7:0] sc,
                                         input logic last);
        t_result r;
        r             = '0;
        r.result_kind = RESULT_CHAR;
        r.char_index  = idx;
        r.char_score  = sc;
        r.last_result = last;
        return r;
    endfunction

    function automatic t_result summary_res(input logic [9:0] cnt, input int sum);
        t_result r;
        r             = '0;
        r.result_kind = RESULT_SUMMARY;
        r.char_count  = cnt;
        r.score_sum   = sum[18:0];
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("kind=%0d idx=%0d score=%0d count=%0d sum=%0d last=%0d",
                         r.result_kind, r.char_index, r.char_score, r.char_count,
                         $signed(r.score_sum), r.last_result);
    endfunction

    // ----------------------------------------------------------- row builders
    function automatic t_stim_row cfg_row(input t_decoder_cfg c);
        t_stim_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.cfg    = c;
        return row;
    endfunction

    function automatic t_stim_row item_row(input logic [7:0] sc, input logic eos);
        t_stim_row row;
        row       = '0;
        row.score = sc;
        row.eos   = eos;
        return row;
    endfunction

    function automatic t_stim_row typed_row(input logic [7:0] sc, input logic eos,
                                            input logic [1:0] n, input t_result r0,
                                            input t_result r1);
        t_stim_row row;
        row       = item_row(sc, eos);
        row.typed = 1'b1;
        row.n     = n;
        row.r0    = r0;
        row.r1    = r1;
        return row;
    endfunction

    // ------------------------------------------------------------ decode model
    // Running argmax per timestep (first index wins a tie), then the CTC greedy
    // collapse at timestep end; fills step_results for one score transaction.
    task automatic decode_score(input logic [7:0] sc, input logic eos);
        int          per_step;
        logic        step_end;
        logic [15:0] winner;
        logic [15:0] dict_offset;
        int          sum_next;
        step_results.delete();
        // class count zero behaves as one: every score closes a timestep
        per_step = (model_cfg.class_count == 16'd0) ? 1 : int'(model_cfg.class_count);
        if (class_pos == 16'd0 || sc > best_score) begin
            best_score = sc;
            best_class = class_pos;
        end
        // early end of sequence closes a partial timestep
        step_end  = eos || (int'(class_pos) + 1 >= per_step);
        class_pos = class_pos + 16'd1;
        if (step_end) begin
            winner    = best_class;
            class_pos = 16'd0;
            if (winner < 16'(model_cfg.ignored)) begin
                // blank: no output, but repeat history now points at the blank
                prev_class = winner;
                prev_known = 1'b1;
            end else if (!(prev_known && winner == prev_class)) begin
                dict_offset = winner - 16'(model_cfg.ignored);
                prev_class  = winner;
                prev_known  = 1'b1;
                if (dict_offset < model_cfg.dict_size) begin
                    step_results.push_back(char_res(dict_offset, best_score, !eos));
                    if (char_total != CHAR_COUNT_MAX) char_total = char_total + 10'd1;
                    sum_next = score_total + int'(best_score) - int'(model_cfg.zero_pt);
                    if (sum_next > SUM_LIMIT)  sum_next = SUM_LIMIT;
                    if (sum_next < -SUM_LIMIT) sum_next = -SUM_LIMIT;
                    score_total = sum_next;
                end
            end
            best_score = 8'd0;
            best_class = 16'd0;
        end
        if (eos) begin
            step_results.push_back(summary_res(char_total, score_total));
            class_pos   = 16'd0;
            best_score  = 8'd0;
            best_class  = 16'd0;
            prev_known  = 1'b0;
            char_total  = 10'd0;
            score_total = 0;
        end
    endtask

    // ------------------------------------------------------------- drivers
    // All tasks are entered and left right after a rising edge.

    // one score transaction; valid stays up until accepted
    task automatic drive_item(input t_stim_row row);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_score           <= row.score;
        i_end_of_sequence <= row.eos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_score(row.score, row.eos);
        if (row.typed) begin
            if (row.n > 2'd0) pending_results.push_back(row.r0);
            if (row.n > 2'd1) pending_results.push_back(row.r1);
        end else begin
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        end
    endtask

    // drop valid, let every owed result drain, then cover results-free work
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // writes all four registers back to back; block must be idle
    task automatic write_config(input t_decoder_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CLASS_COUNT;
        i_cfg_data  <= c.class_count;
        @(posedge i_clk);
        i_cfg_index <= CFG_DICTIONARY_SIZE;
        i_cfg_data  <= c.dict_size;
        @(posedge i_clk);
        i_cfg_index <= CFG_IGNORED_CLASSES;
        i_cfg_data  <= {8'd0, c.ignored};
        @(posedge i_clk);
        i_cfg_index <= CFG_ZERO_POINT;
        i_cfg_data  <= {8'd0, c.zero_pt};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_cfg    = c;
    endtask

    // ------------------------------------------------------ random stimulus
    // extremes show up often, otherwise small timesteps and dictionaries
    function automatic t_decoder_cfg rand_cfg();
        t_decoder_cfg c;
        case ($urandom_range(0, 9))
            0:       c.class_count = 16'd0;
            1:       c.class_count = 16'd1;
            2:       c.class_count = 16'hFFFF;
            default: c.class_count = 16'($urandom_range(2, 8));
        endcase
        case ($urandom_range(0, 3))
            0:       c.ignored = 8'd0;
            1:       c.ignored = 8'hFF;
            default: c.ignored = 8'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 3))
            0:       c.dict_size = 16'd0;
            1:       c.dict_size = 16'hFFFF;
            default: c.dict_size = 16'($urandom_range(0, 8));
        endcase
        case ($urandom_range(0, 3))
            0:       c.zero_pt = 8'd0;
            1:       c.zero_pt = 8'hFF;
            default: c.zero_pt = 8'($urandom);
        endcase
        return c;
    endfunction

    // one timestep worth of scores: noise, a repeat of the last one, or a
    // planted winner (low classes favored so blanks come up)
    task automatic gen_timestep(input int n);
        int         mode;
        int         win;
        logic [7:0] hi;
        mode = $urandom_range(0, 3);
        if (mode == 1 && prev_step.size() != n) mode = 0;
        if (mode == 1) begin
            cur_step = prev_step;
        end else begin
            cur_step.delete();
            win = (mode == 3) ? $urandom_range(0, (n > 1) ? 1 : 0) : $urandom_range(0, n - 1);
            hi  = (mode == 3) ? 8'($urandom_range(128, 255)) : 8'($urandom);
            for (int j = 0; j < n; j++) begin
                if (mode == 0)     cur_step.push_back(8'($urandom));
                else if (j == win) cur_step.push_back(hi);
                else               cur_step.push_back(8'($urandom_range(0, hi)));
            end
        end
        prev_step = cur_step;
    endtask

    task automatic run_random_phase(input int budget);
        int   sent;
        int   per_step;
        int   n_steps;
        int   cut;
        int   pos;
        logic last;
        logic done;
        sent     = 0;
        per_step = (model_cfg.class_count == 16'd0) ? 1 : int'(model_cfg.class_count);
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: raw bytes, stray end markers
                repeat ($urandom_range(1, 6)) begin
                    drive_item(item_row(8'($urandom), $urandom_range(0, 7) == 0));
                    sent++;
                end
            end else if (per_step > 16) begin
                // huge timestep: only reachable through an early end of sequence
                gen_timestep($urandom_range(1, 20));
                foreach (cur_step[j]) begin
                    drive_item(item_row(cur_step[j], j == cur_step.size() - 1));
                    sent++;
                end
            end else begin
                // well-formed sequence, sometimes cut short
                n_steps = $urandom_range(1, 8);
                cut     = ($urandom_range(0, 6) == 0) ?
                          $urandom_range(1, n_steps * per_step) : 0;
                pos     = 0;
                done    = 1'b0;
                for (int t = 0; t < n_steps && !done; t++) begin
                    gen_timestep(per_step);
                    for (int j = 0; j < per_step && !done; j++) begin
                        pos++;
                        last = (t == n_steps - 1 && j == per_step - 1) || pos == cut;
                        drive_item(item_row(cur_step[j], last));
                        sent++;
                        done = last;
                    end
                end
            end
        end
    endtask

    // Long sequence whose winner alternates between classes 1 and 0 at the top
    // score, so every timestep decodes a character. The class count flips
    // between two and one while idle: a low score opens a two-class timestep,
    // the top score then closes it as class 1 under a count of one, and the
    // next top score is a one-class timestep for class 0. Three scores give
    // two characters; drives the count and the sum into saturation.
    task automatic run_saturation();
        t_decoder_cfg c;
        c = '{class_count: 16'd2, dict_size: 16'hFFFF, ignored: 8'd0, zero_pt: 8'd0};
        for (int t = 0; t < SAT_PAIRS; t++) begin
            wait_drained();
            c.class_count = 16'd2;
            write_config(c);
            drive_item(item_row(8'($urandom_range(0, 254)), 1'b0));
            wait_drained();
            c.class_count = 16'd1;
            write_config(c);
            drive_item(item_row(8'hFF, 1'b0));
            drive_item(item_row(8'hFF, t == SAT_PAIRS - 1));
        end
    endtask

    // ------------------------------------------------------------ result side
    // Check the transaction taken at this edge, then pick ready for the next.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_result_kind, o_char_index, o_char_score, o_char_count,
                    o_score_sum, o_last_result};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: %s", fmt_result(got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected %s, got %s",
                                 fmt_result(want), fmt_result(got));
                end
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ----------------------------------------------------------------- main
    initial begin
        // directed table; typed rows are obvious from the rules alone
        // reset config: 2 blanks, zero point 0; lone score -> class 0 blank
        directed_rows.push_back(typed_row(8'hFF, 1'b1, 2'd1, summary_res(10'd0, 0), '0));
        // 3 classes, 1 blank, 1 dictionary entry, zero point 128
        directed_rows.push_back(cfg_row('{class_count: 16'd3, dict_size: 16'd1,
                                          ignored: 8'd1, zero_pt: 8'd128}));
        // tie between classes 1 and 2 -> class 1, decoded
        directed_rows.push_back(item_row(8'd10, 1'b0));
        directed_rows.push_back(item_row(8'd200, 1'b0));
        directed_rows.push_back(item_row(8'd200, 1'b0));
        // same winner again -> repeat dropped
        directed_rows.push_back(item_row(8'd10, 1'b0));
        directed_rows.push_back(item_row(8'd200, 1'b0));
        directed_rows.push_back(item_row(8'd200, 1'b0));
        // blank wins -> no output, history now points at the blank
        directed_rows.push_back(item_row(8'd255, 1'b0));
        directed_rows.push_back(item_row(8'd0, 1'b0));
        directed_rows.push_back(item_row(8'd0, 1'b0));
        // class 1 again, decoded after the blank
        directed_rows.push_back(item_row(8'd10, 1'b0));
        directed_rows.push_back(item_row(8'd200, 1'b0));
        directed_rows.push_back(item_row(8'd200, 1'b0));
        // class 2 is past the dictionary -> skipped
        directed_rows.push_back(item_row(8'd0, 1'b0));
        directed_rows.push_back(item_row(8'd0, 1'b0));
        directed_rows.push_back(item_row(8'd9, 1'b0));
        // early end: partial timestep gives a character, then the summary
        directed_rows.push_back(item_row(8'd0, 1'b0));
        directed_rows.push_back(item_row(8'd77, 1'b1));
        // class count zero acts as one; no blanks, zero point 255
        directed_rows.push_back(cfg_row('{class_count: 16'd0, dict_size: 16'hFFFF,
                                          ignored: 8'd0, zero_pt: 8'hFF}));
        directed_rows.push_back(typed_row(8'hFF, 1'b0, 2'd1,
                                          char_res(16'd0, 8'hFF, 1'b1), '0));
        directed_rows.push_back(typed_row(8'd0, 1'b1, 2'd1, summary_res(10'd1, 0), '0));
        // widest timestep, classes 0 to 254 blanks, empty dictionary
        directed_rows.push_back(cfg_row('{class_count: 16'hFFFF, dict_size: 16'd0,
                                          ignored: 8'hFF, zero_pt: 8'd0}));
        directed_rows.push_back(typed_row(8'd0, 1'b1, 2'd1, summary_res(10'd0, 0), '0));

        model_cfg   = '{class_count: RST_CLASS_COUNT, dict_size: RST_DICTIONARY_SIZE,
                        ignored: RST_IGNORED_CLASSES, zero_pt: RST_ZERO_POINT};
        class_pos   = 16'd0;
        best_score  = 8'd0;
        best_class  = 16'd0;
        prev_class  = 16'd0;
        prev_known  = 1'b0;
        char_total  = 10'd0;
        score_total = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                wait_drained();
                write_config(directed_rows[k].cfg);
            end else begin
                drive_item(directed_rows[k]);
            end
        end

        // random phases; idle mode rotates: none, sender, receiver, both light
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            write_config(rand_cfg());
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 87; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 87; end
                default: begin send_idle = 9; recv_stall = 9; end
            endcase
            run_random_phase(PHASE_ITEMS);
        end

        // count and sum saturation
        wait_drained();
        send_idle  = 0;
        recv_stall = 0;
        run_saturation();

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
